// File: rtl/core/cpms_pkg.sv
// package for the mean shift change point adjustment block
// word types, register indexes, sequencer states and width constants; no dependencies
package cpms_pkg;

   localparam int SAMPLE_W        = 32;
   localparam int CIDX_W          = 7;
   localparam int IDX_W           = 6;
   localparam int MEAN_W          = 33;
   localparam int CSR_INDEX_W     = 2;
   localparam int MAX_SAMPLES_DEF = 64;

   localparam logic [CSR_INDEX_W-1:0] CSR_CHANGE_INDEX    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_USE_GIVEN_SHIFT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GIVEN_SHIFT     = 2'd2;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       last;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] adjusted_sample;
      logic [IDX_W-1:0]           sample_index;
      logic signed [SAMPLE_W-1:0] shift_used;
      logic                       status;
      logic                       last_out;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SUM,
      ST_DIV,
      ST_POST,
      ST_SHIFT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic busy;
      logic accept;
      logic sweep_issue;
      logic sweep_done;
   } ctl_type;

endpackage

// File: rtl/core/change_point_mean_shift_adjust.sv
// Samples load at one per cycle while busy is low; start with last set ends the series.
// The block then sweeps the sample memory once to form the two sums, runs two restoring
// divisions on one shared shift-subtract unit and forms the difference of the two means
// (both skipped when a given shift is used or a part is empty), then replays the series,
// one result word per cycle with a strobe. Results cannot be stalled by the receiver.
// Depends on cpms_pkg.
module change_point_mean_shift_adjust #(
   parameter int MAX_SAMPLES = cpms_pkg::MAX_SAMPLES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  cpms_pkg::req_type                    req_data,
   output logic                                 rsp_valid,
   output cpms_pkg::rsp_type                    rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [cpms_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [cpms_pkg::SAMPLE_W-1:0]        csr_data
);
   import cpms_pkg::*;

   localparam int AW    = $clog2(MAX_SAMPLES);
   localparam int CW    = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_W = SAMPLE_W + AW;
   localparam int DCW   = $clog2(SUM_W);

   localparam logic signed [SAMPLE_W:0] SAT_MAX = (SAMPLE_W+1)'(2147483647);
   localparam logic signed [SAMPLE_W:0] SAT_MIN = -(SAT_MAX + 1);

   // configuration
   logic [CIDX_W-1:0]          change_index_ff;
   logic                       use_given_ff;
   logic signed [SAMPLE_W-1:0] given_shift_ff;

   // sequencer and datapath
   state_type                  state_ff, state_in;
   ctl_type                    ctl;
   logic [CW-1:0]              count_ff;
   logic                       overflow_ff;
   logic [CW-1:0]              ptr_ff;
   logic                       pend_ff;
   logic [AW-1:0]              pend_idx_ff;
   logic signed [SUM_W-1:0]    sum_before_ff;
   logic signed [SUM_W-1:0]    sum_after_ff;
   logic [CW-1:0]              na_ff;
   logic [SUM_W-1:0]           quo_ff;
   logic [CW-1:0]              rem_ff;
   logic [CW-1:0]              div_d_ff;
   logic [DCW-1:0]             cnt_ff;
   logic                       neg_ff;
   logic                       sel_ff;
   logic signed [MEAN_W-1:0]   mb_ff;
   logic signed [MEAN_W-1:0]   ma_ff;
   logic signed [MEAN_W-1:0]   shift_ff;
   logic                       rsp_valid_ff;
   rsp_type                    rsp_ff;

   // memory
   logic [SAMPLE_W-1:0]        mem [MAX_SAMPLES];
   logic [SAMPLE_W-1:0]        rd_data_ff;

   // combinational helpers
   logic [CIDX_W-1:0]          n_ext;
   logic [CIDX_W-1:0]          nb_ext;
   logic [CW-1:0]              nb_now;
   logic [CW-1:0]              na_now;
   logic [CW:0]                rem_sh;
   logic                       div_ge;
   logic [CW:0]                rem_diff;
   logic [SUM_W-1:0]           quo_next;
   logic signed [MEAN_W-1:0]   quo_mean;
   logic signed [MEAN_W-1:0]   mean_now;
   logic                       after_cp;
   logic signed [SAMPLE_W+1:0] adj_wide;
   logic signed [SAMPLE_W-1:0] adj_sat;
   logic signed [SAMPLE_W-1:0] shift_sat;
   logic                       skip_div;

   assign csr_ready = 1'b1;
   assign busy      = ctl.busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // part counts
   always_comb begin
      n_ext  = CIDX_W'(count_ff);
      nb_ext = (change_index_ff < n_ext) ? change_index_ff : n_ext;
      nb_now = CW'(nb_ext);
      na_now = count_ff - nb_now;
      skip_div = use_given_ff || (nb_now == '0) || (na_now == '0);
   end

   // shared shift-subtract step
   always_comb begin
      rem_sh   = {rem_ff, quo_ff[SUM_W-1]};
      rem_diff = rem_sh - {1'b0, div_d_ff};
      div_ge   = (rem_sh >= {1'b0, div_d_ff});
      quo_next = {quo_ff[SUM_W-2:0], div_ge};
      quo_mean = MEAN_W'(quo_ff);
      mean_now = neg_ff ? -quo_mean : quo_mean;
   end

   // replay arithmetic
   always_comb begin
      after_cp = (CIDX_W'(pend_idx_ff) >= change_index_ff);
      adj_wide = (SAMPLE_W+2)'($signed(rd_data_ff));
      if (after_cp) begin
         adj_wide = adj_wide - (SAMPLE_W+2)'(shift_ff);
      end
      if (adj_wide > (SAMPLE_W+2)'(SAT_MAX)) begin
         adj_sat = SAMPLE_W'(SAT_MAX);
      end else if (adj_wide < (SAMPLE_W+2)'(SAT_MIN)) begin
         adj_sat = SAMPLE_W'(SAT_MIN);
      end else begin
         adj_sat = SAMPLE_W'(adj_wide);
      end
      if (shift_ff > SAT_MAX) begin
         shift_sat = SAMPLE_W'(SAT_MAX);
      end else if (shift_ff < SAT_MIN) begin
         shift_sat = SAMPLE_W'(SAT_MIN);
      end else begin
         shift_sat = SAMPLE_W'(shift_ff);
      end
   end

   // control decode
   always_comb begin
      ctl.busy        = (state_ff != ST_LOAD);
      ctl.accept      = start && (state_ff == ST_LOAD);
      ctl.sweep_issue = ((state_ff == ST_SUM) || (state_ff == ST_EMIT)) && (ptr_ff < count_ff);
      ctl.sweep_done  = (ptr_ff == count_ff) && !pend_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (ctl.accept && req_data.last) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            if (ctl.sweep_done) begin
               state_in = skip_div ? ST_EMIT : ST_DIV;
            end
         end
         ST_DIV: begin
            if (cnt_ff == DCW'(SUM_W - 1)) begin
               state_in = ST_POST;
            end
         end
         ST_POST: begin
            state_in = sel_ff ? ST_SHIFT : ST_DIV;
         end
         ST_SHIFT: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (ctl.sweep_done) begin
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // sample memory
   always_ff @(posedge clock) begin
      if (ctl.accept && (count_ff < CW'(MAX_SAMPLES))) begin
         mem[count_ff[AW-1:0]] <= req_data.sample;
      end
      rd_data_ff <= mem[ptr_ff[AW-1:0]];
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         change_index_ff <= '0;
         use_given_ff    <= 1'b0;
         given_shift_ff  <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_CHANGE_INDEX:    change_index_ff <= csr_data[CIDX_W-1:0];
            CSR_USE_GIVEN_SHIFT: use_given_ff    <= csr_data[0];
            CSR_GIVEN_SHIFT:     given_shift_ff  <= csr_data;
            default:             ;
         endcase
      end
   end

   // sequencer datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         count_ff      <= '0;
         overflow_ff   <= 1'b0;
         ptr_ff        <= '0;
         pend_ff       <= 1'b0;
         sum_before_ff <= '0;
         sum_after_ff  <= '0;
         shift_ff      <= '0;
         cnt_ff        <= '0;
         sel_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_LOAD: begin
               if (ctl.accept) begin
                  if (count_ff < CW'(MAX_SAMPLES)) begin
                     count_ff <= count_ff + 1'b1;
                  end else begin
                     overflow_ff <= 1'b1;
                  end
                  ptr_ff        <= '0;
                  pend_ff       <= 1'b0;
                  sum_before_ff <= '0;
                  sum_after_ff  <= '0;
               end
            end
            ST_SUM: begin
               pend_ff     <= ctl.sweep_issue;
               pend_idx_ff <= ptr_ff[AW-1:0];
               if (ctl.sweep_issue) begin
                  ptr_ff <= ptr_ff + 1'b1;
               end
               if (pend_ff) begin
                  if (after_cp) begin
                     sum_after_ff <= sum_after_ff + SUM_W'($signed(rd_data_ff));
                  end else begin
                     sum_before_ff <= sum_before_ff + SUM_W'($signed(rd_data_ff));
                  end
               end
               if (ctl.sweep_done) begin
                  ptr_ff   <= '0;
                  na_ff    <= na_now;
                  quo_ff   <= sum_before_ff[SUM_W-1] ? SUM_W'(-sum_before_ff)
                                                     : SUM_W'(sum_before_ff);
                  neg_ff   <= sum_before_ff[SUM_W-1];
                  div_d_ff <= nb_now;
                  rem_ff   <= '0;
                  cnt_ff   <= '0;
                  sel_ff   <= 1'b0;
                  if (use_given_ff) begin
                     shift_ff <= MEAN_W'(given_shift_ff);
                  end else if (skip_div) begin
                     shift_ff <= '0;
                  end
               end
            end
            ST_DIV: begin
               quo_ff <= quo_next;
               rem_ff <= div_ge ? rem_diff[CW-1:0] : rem_sh[CW-1:0];
               cnt_ff <= cnt_ff + 1'b1;
            end
            ST_POST: begin
               if (!sel_ff) begin
                  mb_ff    <= mean_now;
                  quo_ff   <= sum_after_ff[SUM_W-1] ? SUM_W'(-sum_after_ff)
                                                    : SUM_W'(sum_after_ff);
                  neg_ff   <= sum_after_ff[SUM_W-1];
                  div_d_ff <= na_ff;
                  rem_ff   <= '0;
                  cnt_ff   <= '0;
                  sel_ff   <= 1'b1;
               end else begin
                  ma_ff <= mean_now;
               end
            end
            ST_SHIFT: begin
               shift_ff <= ma_ff - mb_ff;
            end
            ST_EMIT: begin
               pend_ff     <= ctl.sweep_issue;
               pend_idx_ff <= ptr_ff[AW-1:0];
               if (ctl.sweep_issue) begin
                  ptr_ff <= ptr_ff + 1'b1;
               end
               if (pend_ff) begin
                  rsp_valid_ff           <= 1'b1;
                  rsp_ff.adjusted_sample <= adj_sat;
                  rsp_ff.sample_index    <= IDX_W'(pend_idx_ff);
                  rsp_ff.shift_used      <= shift_sat;
                  rsp_ff.status          <= overflow_ff;
                  rsp_ff.last_out        <= (CW'(pend_idx_ff) + 1'b1 == count_ff);
               end
               if (ctl.sweep_done) begin
                  count_ff      <= '0;
                  overflow_ff   <= 1'b0;
                  ptr_ff        <= '0;
                  sum_before_ff <= '0;
                  sum_after_ff  <= '0;
               end
            end
            default: ;
         endcase
      end
   end

endmodule
